>>> src/tpq_pkg.sv
// ----------------------------------------------------------------------------
// tpq_pkg
// Shared types and codes for the timestamp priority queue.
// ----------------------------------------------------------------------------
package tpq_pkg;

    localparam int ERR_W = 2;

    typedef enum logic
    {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } op_t;

    typedef enum logic [ERR_W-1:0]
    {
        ERR_OK    = 2'd0,
        ERR_FULL  = 2'd1,
        ERR_EMPTY = 2'd2
    } err_t;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_CMP,
        ST_PLACE,
        ST_HEAD,
        ST_DONE
    } st_t;

endpackage

>>> src/timestamp_priority_queue.sv
// ----------------------------------------------------------------------------
// timestamp_priority_queue
// Queue of (timestamp, id) entries kept sorted by timestamp, then id.
//
// Input channel s_*: one item per insert or remove; s_tuser is the opcode
// (0 insert, 1 remove), s_tdata carries the entry. Output channel m_*: one
// item per input item with the head entry, the count and an error code.
// Entries live in a circular buffer in one RAM. A remove advances the head
// pointer. An insert walks from the tail toward the head, moving one entry
// up per cycle until it meets a key not larger than its own; entries with
// equal keys keep arrival order. Insert into a full queue is dropped with
// error 1, remove from an empty queue reports error 2.
// One item is in work at a time; s_tready rises the cycle after the result
// is loaded, so the RAM port walk of the insert sets the throughput.
// Reset empties the queue at once (no clearing pass); entry storage is not
// cleared. If the receiver stalls, one result waits in the output register
// and the next item is still taken; its result waits until the first leaves.
// ----------------------------------------------------------------------------
module timestamp_priority_queue #(
    parameter int DEPTH     = 16,
    parameter int ID_BITS   = 4,
    parameter int TIME_BITS = 15
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    // entry_id, entry_time, zero pad
    input  logic [((ID_BITS+TIME_BITS+7)/8)*8-1:0] s_tdata,
    // opcode
    input  logic                     s_tuser,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    // head_id, head_time, entry_count, error_code, zero pad
    output logic [((ID_BITS+TIME_BITS+$clog2(DEPTH+1)+tpq_pkg::ERR_W+7)/8)*8-1:0] m_tdata,
    // head_valid
    output logic                     m_tuser
);

    import tpq_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int KEY_W = TIME_BITS + ID_BITS;
    localparam int OUT_N = KEY_W + CNT_W + ERR_W;
    localparam int OUT_W = ((OUT_N + 7) / 8) * 8;

    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [KEY_W-1:0] ram_wdata;
    logic             ram_re;
    logic [IDX_W-1:0] ram_raddr;
    logic [KEY_W-1:0] ram_rdata;
    logic [KEY_W-1:0] head_key;
    logic [CNT_W-1:0] count;
    logic [ERR_W-1:0] err;

    tpq_ram #(
        .WIDTH (KEY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // key is {time, id}, matching the tdata layout, so one compare orders it
    tpq_ctrl #(
        .DEPTH     (DEPTH),
        .ID_BITS   (ID_BITS),
        .TIME_BITS (TIME_BITS)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (s_tvalid),
        .in_ready       (s_tready),
        .in_op          (s_tuser),
        .in_key         (s_tdata[KEY_W-1:0]),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .out_head_valid (m_tuser),
        .out_head_key   (head_key),
        .out_count      (count),
        .out_err        (err),
        .ram_we         (ram_we),
        .ram_waddr      (ram_waddr),
        .ram_wdata      (ram_wdata),
        .ram_re         (ram_re),
        .ram_raddr      (ram_raddr),
        .ram_rdata      (ram_rdata)
    );

    assign m_tdata = OUT_W'({err, count, head_key});

endmodule

>>> src/tpq_ram.sv
// ----------------------------------------------------------------------------
// tpq_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module tpq_ram #(
    parameter int WIDTH = 19,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> src/tpq_ctrl.sv
// ----------------------------------------------------------------------------
// tpq_ctrl
// Circular sorted buffer control: insertion by shifting entries one slot per
// cycle from the tail, removal by advancing the head, head readback and the
// result register.
// ----------------------------------------------------------------------------
module tpq_ctrl #(
    parameter int DEPTH     = 16,
    parameter int ID_BITS   = 4,
    parameter int TIME_BITS = 15
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // item in
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               in_op,
    input  logic [TIME_BITS+ID_BITS-1:0]       in_key,
    // result out
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic                               out_head_valid,
    output logic [TIME_BITS+ID_BITS-1:0]       out_head_key,
    output logic [$clog2(DEPTH+1)-1:0]         out_count,
    output logic [tpq_pkg::ERR_W-1:0]          out_err,
    // entry memory
    output logic                               ram_we,
    output logic [$clog2(DEPTH)-1:0]           ram_waddr,
    output logic [TIME_BITS+ID_BITS-1:0]       ram_wdata,
    output logic                               ram_re,
    output logic [$clog2(DEPTH)-1:0]           ram_raddr,
    input  logic [TIME_BITS+ID_BITS-1:0]       ram_rdata
);

    import tpq_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int KEY_W = TIME_BITS + ID_BITS;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    st_t              state_reg, state_next;
    logic [IDX_W-1:0] hp_reg, hp_next;
    logic [IDX_W-1:0] tp_reg, tp_next;
    logic [IDX_W-1:0] wp_reg, wp_next;
    logic [IDX_W-1:0] rp_reg, rp_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] j_reg, j_next;
    err_t             err_reg, err_next;
    logic [KEY_W-1:0] key_reg;
    logic             load_out;

    logic             out_valid_reg;
    logic             out_hv_reg;
    logic [KEY_W-1:0] out_key_reg;
    logic [CNT_W-1:0] out_count_reg;
    err_t             out_err_reg;

    function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] idx);
        return (idx == LAST_IDX) ? '0 : idx + IDX_W'(1);
    endfunction

    function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] idx);
        return (idx == '0) ? LAST_IDX : idx - IDX_W'(1);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            hp_reg        <= '0;
            tp_reg        <= '0;
            wp_reg        <= '0;
            rp_reg        <= '0;
            cnt_reg       <= '0;
            j_reg         <= '0;
            err_reg       <= ERR_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            hp_reg    <= hp_next;
            tp_reg    <= tp_next;
            wp_reg    <= wp_next;
            rp_reg    <= rp_next;
            cnt_reg   <= cnt_next;
            j_reg     <= j_next;
            err_reg   <= err_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            key_reg <= in_key;
        end
        if (load_out)
        begin
            out_hv_reg    <= (cnt_reg != '0);
            out_key_reg   <= (cnt_reg != '0) ? ram_rdata : '0;
            out_count_reg <= cnt_reg;
            out_err_reg   <= err_reg;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        hp_next    = hp_reg;
        tp_next    = tp_reg;
        wp_next    = wp_reg;
        rp_next    = rp_reg;
        cnt_next   = cnt_reg;
        j_next     = j_reg;
        err_next   = err_reg;
        ram_we     = 1'b0;
        ram_waddr  = wp_reg;
        ram_wdata  = key_reg;
        ram_re     = 1'b0;
        ram_raddr  = rp_reg;
        load_out   = 1'b0;
        in_ready   = (state_reg == ST_IDLE);

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    err_next = ERR_OK;
                    if (in_op == OP_INSERT)
                    begin
                        if (cnt_reg == FULL_CNT)
                        begin
                            err_next   = ERR_FULL;
                            state_next = ST_HEAD;
                        end
                        else
                        begin
                            // new item starts at the tail slot and sinks toward the head
                            wp_next  = tp_reg;
                            j_next   = cnt_reg;
                            tp_next  = idx_inc(tp_reg);
                            cnt_next = cnt_reg + CNT_W'(1);
                            if (cnt_reg == '0)
                            begin
                                state_next = ST_PLACE;
                            end
                            else
                            begin
                                rp_next    = idx_dec(tp_reg);
                                ram_re     = 1'b1;
                                ram_raddr  = idx_dec(tp_reg);
                                state_next = ST_CMP;
                            end
                        end
                    end
                    else
                    begin
                        if (cnt_reg == '0)
                        begin
                            err_next = ERR_EMPTY;
                        end
                        else
                        begin
                            hp_next  = idx_inc(hp_reg);
                            cnt_next = cnt_reg - CNT_W'(1);
                        end
                        state_next = ST_HEAD;
                    end
                end
            end

            ST_CMP:
            begin
                ram_we = 1'b1;
                // equal keys stay ahead of the new item
                if (ram_rdata > key_reg)
                begin
                    ram_wdata = ram_rdata;
                    wp_next   = rp_reg;
                    j_next    = j_reg - CNT_W'(1);
                    if (j_reg == CNT_W'(1))
                    begin
                        state_next = ST_PLACE;
                    end
                    else
                    begin
                        rp_next   = idx_dec(rp_reg);
                        ram_re    = 1'b1;
                        ram_raddr = idx_dec(rp_reg);
                    end
                end
                else
                begin
                    state_next = ST_HEAD;
                end
            end

            ST_PLACE:
            begin
                ram_we     = 1'b1;
                state_next = ST_HEAD;
            end

            ST_HEAD:
            begin
                ram_re     = 1'b1;
                ram_raddr  = hp_reg;
                state_next = ST_DONE;
            end

            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid      = out_valid_reg;
    assign out_head_valid = out_hv_reg;
    assign out_head_key   = out_key_reg;
    assign out_count      = out_count_reg;
    assign out_err        = out_err_reg;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= FULL_CNT)
        else $error("entry count above depth");

    a_full_err: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_err_reg == ERR_FULL) |-> out_count_reg == FULL_CNT)
        else $error("full error reported on a queue with room");

    a_empty_err: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_err_reg == ERR_EMPTY) |-> (out_count_reg == '0) && !out_hv_reg)
        else $error("empty error reported on a queue holding entries");

    a_shift_left: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CMP |-> j_reg != '0)
        else $error("compare step with no entry left to move");

    a_insert_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_op == OP_INSERT) && (cnt_reg != FULL_CNT)
        |=> cnt_reg == $past(cnt_reg) + CNT_W'(1))
        else $error("insert did not raise the entry count");

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for timestamp_priority_queue. A behavioral copy of the
// sorted queue predicts the head, count and error code of every accepted item.
// Each result is compared field by field with the oldest prediction.
// Directed tests cover the key extremes, tie ordering, a full queue and an
// empty queue. Random traffic then fills and drains the queue with wide and
// narrow keys, while both sides idle at random.
// ----------------------------------------------------------------------------
module testbench;

    import tpq_pkg::*;

    localparam int DEPTH      = 16;
    localparam int ID_BITS    = 4;
    localparam int TIME_BITS  = 15;
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int S_W        = ((ID_BITS + TIME_BITS + 7) / 8) * 8;
    localparam int M_W        = ((ID_BITS + TIME_BITS + CNT_W + ERR_W + 7) / 8) * 8;
    localparam int IDLE_LIMIT = 2000;

    // time in the upper bits so a plain compare orders by time, then id
    typedef struct packed
    {
        logic [TIME_BITS-1:0] ts;
        logic [ID_BITS-1:0]   id;
    } slot_t;

    typedef struct packed
    {
        logic                 hv;
        logic [ID_BITS-1:0]   id;
        logic [TIME_BITS-1:0] ts;
        logic [CNT_W-1:0]     cnt;
        err_t                 err;
    } head_report_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [S_W-1:0]   s_tdata = '0;
    logic             s_tuser = 1'b0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [M_W-1:0]   m_tdata;
    logic             m_tuser;

    slot_t            held_slots [DEPTH];
    int               held_cnt = 0;
    head_report_t     head_expect_q [$];
    int               mismatches = 0;
    int               tx_idle_max = 18;
    int               rx_idle_max = 18;
    int               rx_wait = 0;
    int               quiet_cycles = 0;

    timestamp_priority_queue #(
        .DEPTH     (DEPTH),
        .ID_BITS   (ID_BITS),
        .TIME_BITS (TIME_BITS)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // applies one operation to the shadow queue and returns the report
    function automatic head_report_t queue_step(op_t op, slot_t ent);
        head_report_t r;
        int           pos;
        r = '0;
        r.err = ERR_OK;
        if (op == OP_INSERT)
        begin
            if (held_cnt >= DEPTH)
                r.err = ERR_FULL;
            else
            begin
                pos = held_cnt;
                for (int k = held_cnt - 1; k >= 0; k--)
                    if (held_slots[k] > ent)
                        pos = k;
                for (int k = held_cnt; k > pos; k--)
                    held_slots[k] = held_slots[k-1];
                held_slots[pos] = ent;
                held_cnt++;
            end
        end
        else
        begin
            if (held_cnt == 0)
                r.err = ERR_EMPTY;
            else
            begin
                for (int k = 1; k < held_cnt; k++)
                    held_slots[k-1] = held_slots[k];
                held_cnt--;
            end
        end
        r.hv  = (held_cnt > 0);
        r.id  = r.hv ? held_slots[0].id : '0;
        r.ts  = r.hv ? held_slots[0].ts : '0;
        r.cnt = held_cnt[CNT_W-1:0];
        return r;
    endfunction

    // called at a rising edge; returns at the edge that accepts the item
    task automatic send_item(op_t op, logic [ID_BITS-1:0] id, logic [TIME_BITS-1:0] ts);
        int    gap;
        slot_t ent;
        gap = $urandom_range(tx_idle_max, 0);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{(S_W - ID_BITS - TIME_BITS){1'b0}}, ts, id};
        do
            @(posedge clk);
        while (!s_tready);
        ent.ts = ts;
        ent.id = id;
        head_expect_q.push_back(queue_step(op, ent));
    endtask

    task automatic check_report();
        head_report_t want;
        head_report_t got;
        got.hv  = m_tuser;
        got.id  = m_tdata[ID_BITS-1:0];
        got.ts  = m_tdata[ID_BITS +: TIME_BITS];
        got.cnt = m_tdata[ID_BITS + TIME_BITS +: CNT_W];
        got.err = err_t'(m_tdata[ID_BITS + TIME_BITS + CNT_W +: ERR_W]);
        if (head_expect_q.size() == 0)
        begin
            $display("%0t: unexpected result hv=%0d id=%0d time=%0d count=%0d err=%0d",
                     $time, got.hv, got.id, got.ts, got.cnt, got.err);
            mismatches++;
        end
        else
        begin
            want = head_expect_q.pop_front();
            if (got.hv !== want.hv)
            begin
                $display("%0t: head_valid expected %0d actual %0d", $time, want.hv, got.hv);
                mismatches++;
            end
            if (got.id !== want.id)
            begin
                $display("%0t: head_id expected %0d actual %0d", $time, want.id, got.id);
                mismatches++;
            end
            if (got.ts !== want.ts)
            begin
                $display("%0t: head_time expected %0d actual %0d", $time, want.ts, got.ts);
                mismatches++;
            end
            if (got.cnt !== want.cnt)
            begin
                $display("%0t: entry_count expected %0d actual %0d",
                         $time, want.cnt, got.cnt);
                mismatches++;
            end
            if (got.err !== want.err)
            begin
                $display("%0t: error_code expected %0d actual %0d",
                         $time, want.err, got.err);
                mismatches++;
            end
        end
    endtask

    // result side: check each item, then stall for a random number of cycles
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            rx_wait = 0;
        end
        else if (m_tvalid && m_tready)
        begin
            check_report();
            rx_wait = $urandom_range(rx_idle_max, 0);
            m_tready <= (rx_wait == 0);
        end
        else if (!m_tready)
        begin
            if (rx_wait <= 1)
                m_tready <= 1'b1;
            rx_wait--;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= IDLE_LIMIT)
            begin
                $display("timestamp_priority_queue verification failed");
                $finish;
            end
        end
    end

    task automatic test_empty_remove();
        send_item(OP_REMOVE, '1, '1);
    endtask

    task automatic test_key_order();
        send_item(OP_INSERT, 4'd15, 15'h7fff);
        send_item(OP_INSERT, 4'd9, 15'd100);
        // same time, smaller id takes the head
        send_item(OP_INSERT, 4'd3, 15'd100);
        // equal key goes behind the one already held
        send_item(OP_INSERT, 4'd3, 15'd100);
        send_item(OP_INSERT, 4'd0, 15'd0);
        repeat (5) send_item(OP_REMOVE, 4'd0, 15'd0);
        send_item(OP_REMOVE, 4'd0, 15'd0);
    endtask

    task automatic test_full_queue();
        int fill;
        fill = DEPTH - held_cnt;
        // descending times so each insert walks the whole queue
        for (int k = 0; k < fill; k++)
            send_item(OP_INSERT, 4'(k), 15'(20000 - 7 * k));
        send_item(OP_INSERT, '1, '1);
        send_item(OP_INSERT, '0, '0);
    endtask

    task automatic random_phase(int items, int insert_pct, bit narrow, int idle_max);
        logic [ID_BITS-1:0]   id;
        logic [TIME_BITS-1:0] ts;
        op_t                  op;
        tx_idle_max = idle_max;
        rx_idle_max = idle_max;
        for (int n = 0; n < items; n++)
        begin
            op = ($urandom_range(99, 0) < insert_pct) ? OP_INSERT : OP_REMOVE;
            if (narrow)
            begin
                // few distinct keys to force ties
                ts = TIME_BITS'($urandom_range(3, 0));
                id = ID_BITS'($urandom_range(2, 0));
            end
            else
            begin
                ts = TIME_BITS'($urandom);
                id = ID_BITS'($urandom);
            end
            send_item(op, id, ts);
        end
    endtask

    task automatic test_random_traffic();
        random_phase(50, 80, 1'b0, 18);
        random_phase(50, 25, 1'b1, 18);
        random_phase(50, 50, 1'b0, 0);
        random_phase(50, 90, 1'b1, 18);
        random_phase(50, 10, 1'b0, 18);
        random_phase(50, 55, 1'b1, 0);
        random_phase(50, 65, 1'b0, 18);
        random_phase(50, 35, 1'b0, 18);
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        test_empty_remove();
        test_key_order();
        test_full_queue();
        test_random_traffic();
        s_tvalid <= 1'b0;
        while (head_expect_q.size() != 0)
            @(posedge clk);
        repeat (DEPTH + 8) @(posedge clk);
        if (mismatches == 0 && head_expect_q.size() == 0)
            $display("timestamp_priority_queue verification clean");
        else
            $display("timestamp_priority_queue verification failed");
        $finish;
    end

endmodule

>>> filelist.f
src/tpq_pkg.sv
src/tpq_ram.sv
src/tpq_ctrl.sv
src/timestamp_priority_queue.sv
tb/testbench.sv
